>>> rtl/core/tga_stream_decoder_core_assert.svh
// Assertion macros used by the checker of the stream decoder.
`ifndef TGA_STREAM_DECODER_CORE_ASSERT_SVH
`define TGA_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define TGASD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tga stream decoder assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define TGASD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tga stream decoder assertion failed");

`endif

>>> rtl/core/tgasd_pkg.sv
`timescale 1ns / 1ps

package tgasd_pkg;

	typedef enum logic [2:0] {
		PH_SIG,
		PH_SIZE,
		PH_PKT,
		PH_COLOR,
		PH_DROP
	} phase_t;

	localparam logic [1:0] KIND_INFO  = 2'd0;
	localparam logic [1:0] KIND_PIXEL = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SIGNATURE = 3'd1;
	localparam logic [2:0] ERR_SIZE      = 3'd2;
	localparam logic [2:0] ERR_OVERRUN   = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;

	localparam logic [3:0] SIG_LAST_INDEX  = 4'd11;
	localparam logic [3:0] SIG_TYPE_INDEX  = 4'd2;
	localparam logic [7:0] SIG_TYPE_RAW    = 8'd2;
	localparam logic [7:0] SIG_TYPE_RLE    = 8'd10;
	localparam logic [3:0] SIZE_LAST_INDEX = 4'd5;
	localparam logic [7:0] DEPTH_24        = 8'd24;
	localparam logic [7:0] DEPTH_32        = 8'd32;
	localparam logic [7:0] RUN_FLAG        = 8'd128;
	localparam logic [7:0] RUN_BIAS        = 8'd127;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       stream_last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_res;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        has_alpha;
		logic        last_pixel;
		logic [2:0]  error_code;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  header_index;
		logic        rle_mode;
		logic [15:0] width_reg;
		logic [15:0] height_reg;
		logic        four_bytes;
		logic [31:0] pixels_left;
		logic        packet_is_run;
		logic [7:0]  packet_left;
		logic [1:0]  color_index;
		logic        raw_ok;
		logic        rle_ok;
		logic        depth_ok;
	} state_t;

	typedef struct packed {
		logic       we;
		logic [1:0] idx;
	} color_wr_t;

	typedef logic [2:0][7:0] color_t;

	localparam state_t STATE_RESET = '{
		phase:         PH_SIG,
		header_index:  4'd0,
		rle_mode:      1'b0,
		width_reg:     16'd0,
		height_reg:    16'd0,
		four_bytes:    1'b0,
		pixels_left:   32'd0,
		packet_is_run: 1'b0,
		packet_left:   8'd0,
		color_index:   2'd0,
		raw_ok:        1'b1,
		rle_ok:        1'b1,
		depth_ok:      1'b0
	};

	function automatic logic [7:0] sig_byte(input logic [3:0] idx, input logic is_rle);
		logic [7:0] val;
		val = 8'd0;
		if (idx == SIG_TYPE_INDEX) begin
			val = is_rle ? SIG_TYPE_RLE : SIG_TYPE_RAW;
		end
		return val;
	endfunction

endpackage

>>> rtl/core/tga_stream_decoder_core.sv
`timescale 1ns / 1ps

// Decodes a TGA file (raw or RLE, 24 or 32 bits per pixel) handed over one
// byte per request on the byte channel; the stream_last flag marks the final
// byte of a file. Results leave on the result channel: one information
// request after the size bytes, then one pixel request per pixel, where an
// RLE run is a single request carrying its repeat count; an error request ends any file that fails.
// Each accepted byte is decoded combinationally, and its result, if any, is
// offered on the result channel in the cycle after acceptance.
// The block takes one byte per cycle as long as the result register is
// empty or is being emptied in the same cycle.
// When the receiver stalls with a result pending, byte_ready drops until
// that result is taken.
// Reset clears the decoder to the start of a new file and empties the
// result register. After a completed image or an error, bytes are dropped
// until the stream_last byte, which always returns the decoder to the start.
module tga_stream_decoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  tgasd_pkg::in_item_t  byte_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output tgasd_pkg::out_item_t result_data
);

	tgasd_pkg::state_t    state_q;
	tgasd_pkg::state_t    state_nxt;
	tgasd_pkg::color_t    color_q;
	tgasd_pkg::color_wr_t color_wr;
	tgasd_pkg::out_item_t res;
	logic                 res_valid;
	logic                 result_valid_q;
	tgasd_pkg::out_item_t result_data_q;
	logic                 accept;

	assign byte_ready   = !result_valid_q || result_ready;
	assign accept       = byte_valid && byte_ready;
	assign result_valid = result_valid_q;
	assign result_data  = result_data_q;

	tgasd_step u_step (
		.st       (state_q),
		.item     (byte_data),
		.colors   (color_q),
		.nxt      (state_nxt),
		.color_wr (color_wr),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tgasd_pkg::STATE_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (accept && res_valid) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			result_data_q <= res;
		end
		if (accept && color_wr.we) begin
			color_q[color_wr.idx] <= byte_data.file_byte;
		end
	end

endmodule

>>> rtl/core/tgasd_step.sv
`timescale 1ns / 1ps

module tgasd_step (
	input  tgasd_pkg::state_t    st,
	input  tgasd_pkg::in_item_t  item,
	input  tgasd_pkg::color_t    colors,
	output tgasd_pkg::state_t    nxt,
	output tgasd_pkg::color_wr_t color_wr,
	output logic                 res_valid,
	output tgasd_pkg::out_item_t res
);

	logic        raw_ok_n;
	logic        rle_ok_n;
	logic [31:0] area;
	logic [7:0]  cnt;
	logic [1:0]  final_index;
	logic [31:0] rep;
	logic [31:0] left_n;
	logic [7:0]  b;

	assign b    = item.file_byte;
	assign area = {16'd0, st.width_reg} * {16'd0, st.height_reg};

	always_comb begin
		nxt         = st;
		res         = '0;
		res_valid   = 1'b0;
		color_wr.we = 1'b0;
		color_wr.idx = st.color_index;
		raw_ok_n    = st.raw_ok && (b == tgasd_pkg::sig_byte(st.header_index, 1'b0));
		rle_ok_n    = st.rle_ok && (b == tgasd_pkg::sig_byte(st.header_index, 1'b1));
		cnt         = (b < tgasd_pkg::RUN_FLAG) ? b + 8'd1 : b - tgasd_pkg::RUN_BIAS;
		final_index = st.four_bytes ? 2'd3 : 2'd2;
		rep         = (st.rle_mode && st.packet_is_run) ? {24'd0, st.packet_left} : 32'd1;
		if (rep > st.pixels_left) begin
			rep = st.pixels_left;
		end
		left_n = st.pixels_left - rep;

		unique case (st.phase)
			tgasd_pkg::PH_SIG: begin
				nxt.raw_ok = raw_ok_n;
				nxt.rle_ok = rle_ok_n;
				if (st.header_index == tgasd_pkg::SIG_LAST_INDEX) begin
					nxt.header_index = 4'd0;
					if (raw_ok_n || rle_ok_n) begin
						nxt.rle_mode = !raw_ok_n;
						nxt.phase    = tgasd_pkg::PH_SIZE;
					end else begin
						res.kind       = tgasd_pkg::KIND_ERROR;
						res.error_code = tgasd_pkg::ERR_SIGNATURE;
						res_valid      = 1'b1;
						nxt.phase      = tgasd_pkg::PH_DROP;
					end
				end else begin
					nxt.header_index = st.header_index + 4'd1;
				end
			end
			tgasd_pkg::PH_SIZE: begin
				unique case (st.header_index)
					4'd0: nxt.width_reg[7:0]   = b;
					4'd1: nxt.width_reg[15:8]  = b;
					4'd2: nxt.height_reg[7:0]  = b;
					4'd3: nxt.height_reg[15:8] = b;
					4'd4: begin
						nxt.four_bytes = (b == tgasd_pkg::DEPTH_32);
						nxt.depth_ok   = (b == tgasd_pkg::DEPTH_24) || (b == tgasd_pkg::DEPTH_32);
					end
					default: begin
					end
				endcase
				if (st.header_index >= tgasd_pkg::SIZE_LAST_INDEX) begin
					nxt.header_index = 4'd0;
					res_valid        = 1'b1;
					if (st.width_reg == 16'd0 || st.height_reg == 16'd0 || !st.depth_ok) begin
						res.kind       = tgasd_pkg::KIND_ERROR;
						res.error_code = tgasd_pkg::ERR_SIZE;
						nxt.phase      = tgasd_pkg::PH_DROP;
					end else begin
						nxt.pixels_left  = area;
						res.kind         = tgasd_pkg::KIND_INFO;
						res.image_width  = st.width_reg;
						res.image_height = st.height_reg;
						res.has_alpha    = st.four_bytes;
						nxt.color_index  = 2'd0;
						nxt.packet_left  = 8'd0;
						nxt.phase        = st.rle_mode ? tgasd_pkg::PH_PKT : tgasd_pkg::PH_COLOR;
					end
				end else begin
					nxt.header_index = st.header_index + 4'd1;
				end
			end
			tgasd_pkg::PH_PKT: begin
				nxt.packet_is_run = (b >= tgasd_pkg::RUN_FLAG);
				if ({24'd0, cnt} > st.pixels_left) begin
					res.kind       = tgasd_pkg::KIND_ERROR;
					res.error_code = tgasd_pkg::ERR_OVERRUN;
					res_valid      = 1'b1;
					nxt.phase      = tgasd_pkg::PH_DROP;
				end else begin
					nxt.packet_left = cnt;
					nxt.color_index = 2'd0;
					nxt.phase       = tgasd_pkg::PH_COLOR;
				end
			end
			tgasd_pkg::PH_COLOR: begin
				if (st.color_index < final_index) begin
					color_wr.we     = 1'b1;
					nxt.color_index = st.color_index + 2'd1;
				end else begin
					nxt.pixels_left = left_n;
					if (st.rle_mode) begin
						if (st.packet_is_run || st.packet_left == 8'd0) begin
							nxt.packet_left = 8'd0;
						end else begin
							nxt.packet_left = st.packet_left - 8'd1;
						end
					end
					nxt.color_index = 2'd0;
					res.kind        = tgasd_pkg::KIND_PIXEL;
					res.red         = st.four_bytes ? colors[2] : b;
					res.green       = colors[1];
					res.blue        = colors[0];
					res.alpha       = st.four_bytes ? b : 8'd0;
					res.repeat_res  = rep[7:0];
					res.has_alpha   = st.four_bytes;
					res.last_pixel  = (left_n == 32'd0);
					res_valid       = 1'b1;
					if (left_n == 32'd0) begin
						nxt.phase = tgasd_pkg::PH_DROP;
					end else if (st.rle_mode && nxt.packet_left == 8'd0) begin
						nxt.phase = tgasd_pkg::PH_PKT;
					end
				end
			end
			default: begin
			end
		endcase

		if (item.stream_last) begin
			if (nxt.phase != tgasd_pkg::PH_DROP) begin
				res            = '0;
				res.kind       = tgasd_pkg::KIND_ERROR;
				res.error_code = tgasd_pkg::ERR_TRUNCATED;
				res_valid      = 1'b1;
			end
			nxt = tgasd_pkg::STATE_RESET;
		end
	end

endmodule

>>> rtl/core/tgasd_checker.sv
`timescale 1ns / 1ps

`include "tga_stream_decoder_core_assert.svh"

module tgasd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 byte_valid,
	input logic                 byte_ready,
	input tgasd_pkg::in_item_t  byte_data,
	input logic                 result_valid,
	input logic                 result_ready,
	input tgasd_pkg::out_item_t result_data
);

	`TGASD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data))

	`TGASD_ASSERT_NOW(a_stall_blocks, result_valid && !result_ready, !byte_ready)

	`TGASD_ASSERT_NOW(a_pixel_fields, result_valid && result_data.kind == tgasd_pkg::KIND_PIXEL, result_data.repeat_res != 8'd0 && result_data.repeat_res <= 8'd128 && result_data.error_code == tgasd_pkg::ERR_NONE)

	`TGASD_ASSERT_NOW(a_error_fields, result_valid && result_data.kind == tgasd_pkg::KIND_ERROR, result_data.error_code != tgasd_pkg::ERR_NONE && result_data.error_code <= tgasd_pkg::ERR_TRUNCATED && result_data.repeat_res == 8'd0)

	`TGASD_ASSERT_NOW(a_info_fields, result_valid && result_data.kind == tgasd_pkg::KIND_INFO, result_data.image_width != 16'd0 && result_data.image_height != 16'd0)

endmodule

bind tga_stream_decoder_core tgasd_checker u_tgasd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.byte_valid  (byte_valid),
	.byte_ready  (byte_ready),
	.byte_data   (byte_data),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result_data (result_data)
);

>>> dv/tgasd_result_checker.sv
`timescale 1ns / 1ps

module tgasd_result_checker
	import tgasd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	input  logic      byte_ready,
	input  in_item_t  byte_data,
	input  logic      result_valid,
	input  logic      result_ready,
	input  out_item_t result_data,
	output int        errors,
	output int        pending
);

	phase_t      dec_phase;
	logic [3:0]  hdr_idx;
	logic        rle;
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic        four;
	logic [31:0] px_left;
	logic        run_pkt;
	logic [7:0]  pkt_left;
	logic [1:0]  col_idx;
	logic [7:0]  col [3];
	logic        raw_ok;
	logic        rle_ok;
	logic        depth_ok;

	out_item_t pending_results [$];

	function automatic void restart_file();
		dec_phase = PH_SIG;
		hdr_idx = '0;
		rle = 1'b0;
		img_w = '0;
		img_h = '0;
		four = 1'b0;
		px_left = '0;
		run_pkt = 1'b0;
		pkt_left = '0;
		col_idx = '0;
		col[0] = '0;
		col[1] = '0;
		col[2] = '0;
		raw_ok = 1'b1;
		rle_ok = 1'b1;
		depth_ok = 1'b0;
	endfunction

	function automatic bit decode_byte(input in_item_t item, output out_item_t res);
		logic [7:0]  b;
		logic [7:0]  want_raw;
		logic [7:0]  want_rle;
		int unsigned run_len;
		int unsigned rep;
		int unsigned final_idx;
		bit          got;
		b = item.file_byte;
		res = '0;
		got = 1'b0;
		case (dec_phase)
			PH_SIG: begin
				want_raw = (hdr_idx == SIG_TYPE_INDEX) ? SIG_TYPE_RAW : 8'd0;
				want_rle = (hdr_idx == SIG_TYPE_INDEX) ? SIG_TYPE_RLE : 8'd0;
				if (b != want_raw) raw_ok = 1'b0;
				if (b != want_rle) rle_ok = 1'b0;
				if (hdr_idx == SIG_LAST_INDEX) begin
					hdr_idx = '0;
					if (raw_ok || rle_ok) begin
						rle = !raw_ok;
						dec_phase = PH_SIZE;
					end else begin
						res.kind = KIND_ERROR;
						res.error_code = ERR_SIGNATURE;
						got = 1'b1;
						dec_phase = PH_DROP;
					end
				end else begin
					hdr_idx++;
				end
			end
			PH_SIZE: begin
				case (hdr_idx)
					4'd0: img_w[7:0] = b;
					4'd1: img_w[15:8] = b;
					4'd2: img_h[7:0] = b;
					4'd3: img_h[15:8] = b;
					4'd4: begin
						four = (b == DEPTH_32);
						depth_ok = (b == DEPTH_24) || (b == DEPTH_32);
					end
					default: ;
				endcase
				if (hdr_idx == SIZE_LAST_INDEX) begin
					hdr_idx = '0;
					got = 1'b1;
					if (img_w == 0 || img_h == 0 || !depth_ok) begin
						res.kind = KIND_ERROR;
						res.error_code = ERR_SIZE;
						dec_phase = PH_DROP;
					end else begin
						px_left = {16'd0, img_w} * {16'd0, img_h};
						res.kind = KIND_INFO;
						res.image_width = img_w;
						res.image_height = img_h;
						res.has_alpha = four;
						col_idx = '0;
						pkt_left = '0;
						dec_phase = rle ? PH_PKT : PH_COLOR;
					end
				end else begin
					hdr_idx++;
				end
			end
			PH_PKT: begin
				run_pkt = (b >= RUN_FLAG);
				run_len = run_pkt ? b - RUN_BIAS : b + 1;
				if (run_len > px_left) begin
					res.kind = KIND_ERROR;
					res.error_code = ERR_OVERRUN;
					got = 1'b1;
					dec_phase = PH_DROP;
				end else begin
					pkt_left = run_len[7:0];
					col_idx = '0;
					dec_phase = PH_COLOR;
				end
			end
			PH_COLOR: begin
				final_idx = four ? 3 : 2;
				if (col_idx < final_idx) begin
					col[col_idx] = b;
					col_idx++;
				end else begin
					rep = (rle && run_pkt) ? pkt_left : 1;
					if (rep > px_left) rep = px_left;
					px_left = px_left - rep;
					if (rle) begin
						if (run_pkt || pkt_left == 0) pkt_left = '0;
						else pkt_left--;
					end
					col_idx = '0;
					res.kind = KIND_PIXEL;
					res.red = four ? col[2] : b;
					res.green = col[1];
					res.blue = col[0];
					res.alpha = four ? b : 8'd0;
					res.repeat_res = rep[7:0];
					res.has_alpha = four;
					res.last_pixel = (px_left == 0);
					got = 1'b1;
					if (px_left == 0) dec_phase = PH_DROP;
					else if (rle && pkt_left == 0) dec_phase = PH_PKT;
				end
			end
			default: ;
		endcase
		if (item.stream_last) begin
			if (dec_phase != PH_DROP) begin
				res = '0;
				res.kind = KIND_ERROR;
				res.error_code = ERR_TRUNCATED;
				got = 1'b1;
			end
			restart_file();
		end
		return got;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t predicted;
		if (!arst_n) begin
			restart_file();
			pending_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					$error("Result request arrived with no result expected.");
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("kind", want.kind, result_data.kind);
					check_field("red", want.red, result_data.red);
					check_field("green", want.green, result_data.green);
					check_field("blue", want.blue, result_data.blue);
					check_field("alpha", want.alpha, result_data.alpha);
					check_field("repeat_res", want.repeat_res, result_data.repeat_res);
					check_field("image_width", want.image_width, result_data.image_width);
					check_field("image_height", want.image_height,
						result_data.image_height);
					check_field("has_alpha", want.has_alpha, result_data.has_alpha);
					check_field("last_pixel", want.last_pixel, result_data.last_pixel);
					check_field("error_code", want.error_code, result_data.error_code);
				end
			end
			if (byte_valid && byte_ready) begin
				if (decode_byte(byte_data, predicted)) pending_results.push_back(predicted);
			end
			pending = pending_results.size();
		end
	end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tgasd_pkg::*;

	localparam int BYTE_TARGET = 1100;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 10;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_ready;
	in_item_t  byte_data;
	logic      result_valid;
	logic      result_ready;
	out_item_t result_data;

	int errors;
	int pending;
	int cycle_count = 0;
	int bytes_sent = 0;

	in_item_t file_bytes [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	tga_stream_decoder_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	tgasd_result_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.errors       (errors),
		.pending      (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int pick_gap(input bit no_gaps);
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	task automatic send_byte(input in_item_t item, input bit no_gaps);
		int gap;
		gap = pick_gap(no_gaps);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= item;
		do @(posedge clk); while (!byte_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b);
		file_bytes.push_back('{file_byte: b, stream_last: 1'b0});
	endtask

	task automatic add_color(input bit four);
		repeat (four ? 4 : 3) add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic add_junk(input int count);
		repeat (count) add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic add_signature(input bit use_rle, input bit corrupt);
		int bad_idx;
		logic [7:0] b;
		bad_idx = corrupt ? $urandom_range(0, 11) : -1;
		for (int i = 0; i < 12; i++) begin
			b = (i == SIG_TYPE_INDEX) ? (use_rle ? SIG_TYPE_RLE : SIG_TYPE_RAW) : 8'd0;
			if (i == bad_idx) begin
				do b = 8'($urandom_range(0, 255));
				while ((i == SIG_TYPE_INDEX) ? (b == SIG_TYPE_RAW || b == SIG_TYPE_RLE)
					: (b == 8'd0));
			end
			add_byte(b);
		end
	endtask

	task automatic add_sizes(input int w, input int h, input logic [7:0] depth);
		add_byte(8'(w));
		add_byte(8'(w >> 8));
		add_byte(8'(h));
		add_byte(8'(h >> 8));
		add_byte(depth);
		add_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic add_pixels(input bit use_rle, input bit four, input int npix,
			input bit overrun, input bit long_runs);
		int left;
		int cnt;
		int maxc;
		bit run;
		left = npix;
		while (left > 0) begin
			if (!use_rle) begin
				add_color(four);
				left--;
			end else begin
				maxc = (left < 128) ? left : 128;
				if (long_runs && $urandom_range(0, 3) != 0) cnt = maxc;
				else if ($urandom_range(0, 3) == 0) cnt = $urandom_range(1, maxc);
				else cnt = $urandom_range(1, (maxc < 4) ? maxc : 4);
				run = long_runs ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1));
				if (overrun && left < 128 && (cnt == left || $urandom_range(0, 3) == 0)) begin
					cnt = $urandom_range(left + 1, 128);
					add_byte(run ? 8'(cnt + RUN_BIAS) : 8'(cnt - 1));
					return;
				end
				add_byte(run ? 8'(cnt + RUN_BIAS) : 8'(cnt - 1));
				if (run) add_color(four);
				else repeat (cnt) add_color(four);
				left -= cnt;
			end
		end
	endtask

	task automatic send_file();
		bit no_gaps;
		in_item_t item;
		no_gaps = ($urandom_range(0, 3) == 0);
		foreach (file_bytes[i]) begin
			item = file_bytes[i];
			item.stream_last = (i == file_bytes.size() - 1);
			send_byte(item, no_gaps);
		end
		file_bytes.delete();
	endtask

	task automatic random_file();
		int pick;
		int w;
		int h;
		int cut;
		bit use_rle;
		bit four;
		logic [7:0] depth;
		pick = $urandom_range(0, 99);
		use_rle = $urandom_range(0, 1);
		four = $urandom_range(0, 1);
		depth = four ? DEPTH_32 : DEPTH_24;
		w = $urandom_range(1, 4);
		h = $urandom_range(1, 3);
		if (pick < 55) begin
			if ($urandom_range(0, 9) == 0) begin
				use_rle = 1'b1;
				w = $urandom_range(16, 40);
				h = $urandom_range(4, 8);
			end
			add_signature(use_rle, 1'b0);
			add_sizes(w, h, depth);
			add_pixels(use_rle, four, w * h, 1'b0, w >= 16);
			add_junk($urandom_range(0, 3));
		end else if (pick < 68) begin
			if ($urandom_range(0, 1) == 0) begin
				w = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 65535);
				h = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 65535);
			end
			add_signature(use_rle, 1'b0);
			add_sizes(w, h, depth);
			add_pixels(use_rle, four, (w <= 4 && h <= 3) ? w * h : 10, 1'b0, 1'b0);
			cut = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > cut) void'(file_bytes.pop_back());
		end else if (pick < 78) begin
			add_signature(1'b1, 1'b0);
			add_sizes(w, h, depth);
			add_pixels(1'b1, four, w * h, 1'b1, 1'b0);
			add_junk($urandom_range(0, 3));
		end else if (pick < 88) begin
			case ($urandom_range(0, 2))
				0: w = 0;
				1: h = 0;
				default: begin
					do depth = 8'($urandom_range(0, 255));
					while (depth == DEPTH_24 || depth == DEPTH_32);
				end
			endcase
			if ($urandom_range(0, 3) == 0) begin
				if (w != 0) w = $urandom_range(1, 65535);
				if (h != 0) h = $urandom_range(1, 65535);
			end
			add_signature(use_rle, 1'b0);
			add_sizes(w, h, depth);
			add_junk($urandom_range(0, 3));
		end else if (pick < 94) begin
			add_signature(use_rle, 1'b1);
			add_junk($urandom_range(0, 3));
		end else begin
			add_junk($urandom_range(1, 20));
		end
		send_file();
	endtask

	initial begin
		int on_len;
		int off_len;
		int r;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			on_len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
			r = $urandom_range(0, 99);
			if (r < 50) off_len = 0;
			else if (r < 85) off_len = $urandom_range(1, 3);
			else off_len = $urandom_range(4, 30);
			result_ready <= 1'b1;
			repeat (on_len) @(negedge clk);
			if (off_len > 0) begin
				result_ready <= 1'b0;
				repeat (off_len) @(negedge clk);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A lone final byte truncates the file, then an all-ones signature is rejected.
		add_byte(8'hFF);
		send_file();
		repeat (12) add_byte(8'hFF);
		send_file();

		while (bytes_sent < BYTE_TARGET) random_file();
		byte_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
